// File: design/kkh_pkg.sv
// kkh_pkg: shared types and constants of the keypad key hold tracker.
// Holds the request, response and command types and the slot table sizes.
// No dependencies.
package kkh_pkg;

   // Slot table and report sizes
   localparam int SLOTS        = 8;
   localparam int REPORT_LIMIT = 8;
   localparam int LIMIT        = (REPORT_LIMIT < SLOTS) ? REPORT_LIMIT : SLOTS;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W        = $clog2(SLOTS + 1);
   localparam int RPT_W        = $clog2(LIMIT + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Request kinds
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_POLL  = 1'b1;

   // Key phases as reported
   localparam logic [1:0] PH_PRESSED  = 2'd0;
   localparam logic [1:0] PH_HELD     = 2'd1;
   localparam logic [1:0] PH_RELEASED = 2'd2;
   localparam logic [1:0] PH_REL_HELD = 2'd3;

   // Register indexes
   localparam logic CSR_LONG_PRESS = 1'b0;
   localparam logic CSR_KEYPAD_ID  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  key_code;
      logic        pressed;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] report_id;
      logic [7:0] report_key;
      logic [1:0] key_state;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] hold_limit;
      logic [7:0]  keypad_id;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_PRESS,
      CMD_RELEASE,
      CMD_POLL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  key;
      logic [31:0] now_ms;
   } cmd_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: design/kkh_front.sv
// kkh_front: accepts requests, classifies them and drops raw events over
// the per-poll limit. Pushes commands into the queue. Uses kkh_pkg.
module kkh_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  kkh_pkg::req_type          req_data,
   input  kkh_pkg::queue_status_type q_status,
   output logic                      push,
   output kkh_pkg::cmd_type          push_cmd
);

   logic [kkh_pkg::CNT_W-1:0] events_ff, events_in;
   logic                      accept;
   logic                      room;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign room      = events_ff < kkh_pkg::CNT_W'(kkh_pkg::SLOTS);

   // Classify the request
   always_comb begin
      push_cmd.key    = req_data.key_code;
      push_cmd.now_ms = req_data.now_ms;
      if (req_data.func == kkh_pkg::FUNC_POLL) begin
         push_cmd.op = kkh_pkg::CMD_POLL;
      end else if (req_data.pressed) begin
         push_cmd.op = kkh_pkg::CMD_PRESS;
      end else begin
         push_cmd.op = kkh_pkg::CMD_RELEASE;
      end
   end

   assign push = accept && ((req_data.func == kkh_pkg::FUNC_POLL) || room);

   // Raw events since the last poll
   always_comb begin
      events_in = events_ff;
      if (accept) begin
         if (req_data.func == kkh_pkg::FUNC_POLL) begin
            events_in = '0;
         end else if (room) begin
            events_in = events_ff + kkh_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         events_ff <= '0;
      end else begin
         events_ff <= events_in;
      end
   end

endmodule

// File: design/kkh_queue.sv
// kkh_queue: short command queue between front and back.
// Register array with head and tail pointers. Uses kkh_pkg.
module kkh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kkh_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output kkh_pkg::cmd_type          head_cmd,
   output kkh_pkg::queue_status_type status
);

   kkh_pkg::cmd_type           entry_ff [kkh_pkg::QUEUE_DEPTH];
   logic [kkh_pkg::QPTR_W-1:0] head_ff, head_in;
   logic [kkh_pkg::QPTR_W-1:0] tail_ff, tail_in;
   logic [kkh_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign status.full  = count_ff == kkh_pkg::QCNT_W'(kkh_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_cmd     = entry_ff[head_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   // Pointer and count update
   always_comb begin
      head_in  = do_pop  ? head_ff + kkh_pkg::QPTR_W'(1) : head_ff;
      tail_in  = do_push ? tail_ff + kkh_pkg::QPTR_W'(1) : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + kkh_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - kkh_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Payload storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

// File: design/kkh_back.sv
// kkh_back: slot table and poll sequencer. Applies releases, queues presses,
// scans slots one per cycle on a poll unless a report is held by a response
// stall, then applies queued presses. Drives the response register. Uses kkh_pkg.
module kkh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  kkh_pkg::cfg_type          cfg,
   input  kkh_pkg::queue_status_type q_status,
   input  kkh_pkg::cmd_type          head_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kkh_pkg::rsp_type          rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   localparam int SLOTS = kkh_pkg::SLOTS;
   localparam int SW    = kkh_pkg::SLOT_W;
   localparam int CW    = kkh_pkg::CNT_W;
   localparam int RW    = kkh_pkg::RPT_W;

   state_type        state_ff, state_in;
   logic             active_ff [SLOTS];
   logic             active_in [SLOTS];
   logic [7:0]       key_ff    [SLOTS];
   logic [7:0]       key_in    [SLOTS];
   logic [1:0]       phase_ff  [SLOTS];
   logic [1:0]       phase_in  [SLOTS];
   logic [31:0]      down_ff   [SLOTS];
   logic [31:0]      down_in   [SLOTS];
   logic [7:0]       qkey_ff   [SLOTS];
   logic [CW-1:0]    qcnt_ff, qcnt_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [RW-1:0]    rpt_ff, rpt_in;
   logic [31:0]      now_ff, now_in;
   logic             rsp_valid_ff, rsp_valid_in;
   kkh_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             qkey_we;
   logic [7:0]       qkey_wdata;
   logic [31:0]      age;
   logic [1:0]       phase_eff;
   logic             any_above;
   logic             emit;
   logic             advance;
   logic [7:0]       apply_key;
   logic             match_hit, free_hit;
   logic [SW-1:0]    match_idx, free_idx;
   logic [7:0]       find_key;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;

   // Current scan slot: hold test and remaining active slots above it
   always_comb begin
      age       = now_ff - down_ff[idx_ff];
      phase_eff = phase_ff[idx_ff];
      if (phase_ff[idx_ff] == kkh_pkg::PH_PRESSED && age >= {16'd0, cfg.hold_limit}) begin
         phase_eff = kkh_pkg::PH_HELD;
      end
      any_above = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (SW'(j) > idx_ff && active_ff[j]) begin
            any_above = 1'b1;
         end
      end
   end

   // Key lookup: first active slot with the key, first free slot
   assign apply_key = qkey_ff[idx_ff];
   assign find_key  = (state_ff == ST_APPLY) ? apply_key : head_cmd.key;

   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      free_hit  = 1'b0;
      free_idx  = '0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (active_ff[j] && key_ff[j] == find_key) begin
            match_hit = 1'b1;
            match_idx = SW'(j);
         end
         if (!active_ff[j]) begin
            free_hit = 1'b1;
            free_idx = SW'(j);
         end
      end
   end

   assign emit    = (state_ff == ST_SCAN) && active_ff[idx_ff] &&
                    (rpt_ff < RW'(kkh_pkg::LIMIT));
   assign advance = !emit || out_free;

   // Sequencer and slot table next state
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      key_in       = key_ff;
      phase_in     = phase_ff;
      down_in      = down_ff;
      qcnt_in      = qcnt_ff;
      idx_in       = idx_ff;
      rpt_in       = rpt_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      qkey_we      = 1'b0;
      qkey_wdata   = head_cmd.key;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (head_cmd.op)
                  kkh_pkg::CMD_PRESS: begin
                     qkey_we = 1'b1;
                     qcnt_in = qcnt_ff + CW'(1);
                  end
                  kkh_pkg::CMD_RELEASE: begin
                     if (match_hit) begin
                        phase_in[match_idx] = (phase_ff[match_idx] == kkh_pkg::PH_HELD) ?
                                              kkh_pkg::PH_REL_HELD : kkh_pkg::PH_RELEASED;
                     end
                  end
                  kkh_pkg::CMD_POLL: begin
                     now_in   = head_cmd.now_ms;
                     idx_in   = '0;
                     rpt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (advance) begin
               if (emit) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.report_id  = cfg.keypad_id;
                  rsp_data_in.report_key = key_ff[idx_ff];
                  rsp_data_in.key_state  = phase_eff;
                  rsp_data_in.last       = (rpt_ff + RW'(1) == RW'(kkh_pkg::LIMIT)) ||
                                           !any_above;
                  rpt_in                 = rpt_ff + RW'(1);
               end
               if (active_ff[idx_ff]) begin
                  if (phase_eff inside {kkh_pkg::PH_RELEASED, kkh_pkg::PH_REL_HELD}) begin
                     active_in[idx_ff] = 1'b0;
                     phase_in[idx_ff]  = kkh_pkg::PH_PRESSED;
                  end else begin
                     phase_in[idx_ff]  = phase_eff;
                  end
               end
               if (idx_ff == SW'(SLOTS - 1)) begin
                  idx_in   = '0;
                  state_in = (qcnt_ff != '0) ? ST_APPLY : ST_IDLE;
               end else begin
                  idx_in = idx_ff + SW'(1);
               end
            end
         end

         ST_APPLY: begin
            // One queued press per cycle
            if (match_hit) begin
               phase_in[match_idx] = kkh_pkg::PH_PRESSED;
               down_in[match_idx]  = now_ff;
            end else if (free_hit) begin
               active_in[free_idx] = 1'b1;
               key_in[free_idx]    = apply_key;
               phase_in[free_idx]  = kkh_pkg::PH_PRESSED;
               down_in[free_idx]   = now_ff;
            end
            if (CW'(idx_ff) + CW'(1) == qcnt_ff) begin
               qcnt_in  = '0;
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, slot table and response register; payload registers carry no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qcnt_ff      <= '0;
         idx_ff       <= '0;
         rpt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            active_ff[j] <= 1'b0;
            key_ff[j]    <= '0;
            phase_ff[j]  <= kkh_pkg::PH_PRESSED;
            down_ff[j]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         qcnt_ff      <= qcnt_in;
         idx_ff       <= idx_in;
         rpt_ff       <= rpt_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         key_ff       <= key_in;
         phase_ff     <= phase_in;
         down_ff      <= down_in;
      end
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Queued press keys, no reset
   always_ff @(posedge clock) begin
      if (qkey_we) begin
         qkey_ff[qcnt_ff[SW-1:0]] <= qkey_wdata;
      end
   end

endmodule

// File: design/keypad_key_hold_tracker.sv
// keypad_key_hold_tracker: top level, holds the configuration registers.
// A raw event is queued on accept and popped by the back when idle; a release is applied then,
// a press waits for the next poll. A poll is popped, then scans one slot per cycle unless a report
// is held by a response stall, then applies queued presses one per cycle; reports are registered.
// Synchronous reset clears the slot table, counters and queue at once; config gets 1000 and 0.
// Depends on kkh_pkg, kkh_front, kkh_queue, kkh_back.
module keypad_key_hold_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kkh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kkh_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   kkh_pkg::cfg_type          cfg_ff, cfg_in;
   kkh_pkg::queue_status_type q_status;
   kkh_pkg::cmd_type          push_cmd, head_cmd;
   logic                      push, pop;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kkh_pkg::CSR_LONG_PRESS: cfg_in.hold_limit = csr_wdata;
            kkh_pkg::CSR_KEYPAD_ID:  cfg_in.keypad_id  = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_limit <= 16'd1000;
         cfg_ff.keypad_id  <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kkh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   kkh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   kkh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/kkh_checker.sv
// kkh_checker: port-level assertions for keypad_key_hold_tracker.
// Bound to the top level. Depends on kkh_pkg.
module kkh_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input kkh_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kkh_pkg::rsp_type rsp_data
);

   // Stalled request stays offered with the same payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // Stalled response stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Stalled response payload holds
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset empties the queue and the response register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // No report can come out of the sequencer before a poll has gone through
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> ##1 !rsp_valid)
      else $error("response too soon after reset");

endmodule

bind keypad_key_hold_tracker kkh_checker u_kkh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/tb_top.sv
// tb_top: self-checking testbench of keypad_key_hold_tracker.
// Holds a slot-table predictor in a small scoreboard class, request and report drivers, watchdog.
// Depends on kkh_pkg and keypad_key_hold_tracker.
`timescale 1ns / 100ps

module tb_top;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int POOL_SIZE       = 12;
   localparam int PHASE_ITEMS     = 20;

   // Slot table predictor and store of expected key reports
   class key_report_board;
      logic [15:0]      hold_ms;
      logic [7:0]       pad_id;
      logic             slot_used[kkh_pkg::SLOTS];
      logic [7:0]       slot_key[kkh_pkg::SLOTS];
      logic [1:0]       slot_phase[kkh_pkg::SLOTS];
      logic [31:0]      slot_down[kkh_pkg::SLOTS];
      logic [7:0]       press_keys[kkh_pkg::SLOTS];
      int               press_count;
      int               events_since_poll;
      kkh_pkg::rsp_type pending_reports[$];
      int               errors;
      int               requests;
      int               polls;
      int               reports_checked;

      function new();
         hold_ms = 16'd1000;
         pad_id  = 8'd0;
         for (int i = 0; i < kkh_pkg::SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = 8'd0;
            slot_phase[i] = kkh_pkg::PH_PRESSED;
            slot_down[i]  = 32'd0;
            press_keys[i] = 8'd0;
         end
         press_count       = 0;
         events_since_poll = 0;
         errors            = 0;
         requests          = 0;
         polls             = 0;
         reports_checked   = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] value);
         if (idx == kkh_pkg::CSR_LONG_PRESS)
            hold_ms = value;
         else
            pad_id = value[7:0];
      endfunction

      function int find_key(logic [7:0] k);
         for (int i = 0; i < kkh_pkg::SLOTS; i++)
            if (slot_used[i] && slot_key[i] == k)
               return i;
         return -1;
      endfunction

      function int find_free();
         for (int i = 0; i < kkh_pkg::SLOTS; i++)
            if (!slot_used[i])
               return i;
         return -1;
      endfunction

      // Apply one accepted request and queue the reports it causes
      function void predict_reports(kkh_pkg::req_type r);
         int               s;
         int               n;
         logic [31:0]      held_for;
         kkh_pkg::rsp_type rep;
         kkh_pkg::rsp_type prev;
         requests++;
         if (r.func == kkh_pkg::FUNC_EVENT) begin
            if (events_since_poll >= kkh_pkg::SLOTS)
               return;
            events_since_poll++;
            if (r.pressed) begin
               press_keys[press_count] = r.key_code;
               press_count++;
            end else begin
               s = find_key(r.key_code);
               if (s >= 0)
                  slot_phase[s] = (slot_phase[s] == kkh_pkg::PH_HELD) ?
                                  kkh_pkg::PH_REL_HELD : kkh_pkg::PH_RELEASED;
            end
            return;
         end
         polls++;
         // promote keys down long enough
         for (int i = 0; i < kkh_pkg::SLOTS; i++) begin
            if (slot_used[i] && slot_phase[i] == kkh_pkg::PH_PRESSED) begin
               held_for = r.now_ms - slot_down[i];
               if (held_for >= {16'd0, hold_ms})
                  slot_phase[i] = kkh_pkg::PH_HELD;
            end
         end
         // report active slots, free released ones; last mark on final report
         n = 0;
         for (int i = 0; i < kkh_pkg::SLOTS; i++) begin
            if (slot_used[i]) begin
               if (n < kkh_pkg::LIMIT) begin
                  if (n > 0)
                     pending_reports.push_back(prev);
                  rep.report_id  = pad_id;
                  rep.report_key = slot_key[i];
                  rep.key_state  = slot_phase[i];
                  rep.last       = 1'b0;
                  prev = rep;
                  n++;
               end
               if (slot_phase[i] == kkh_pkg::PH_RELEASED ||
                   slot_phase[i] == kkh_pkg::PH_REL_HELD) begin
                  slot_used[i]  = 1'b0;
                  slot_phase[i] = kkh_pkg::PH_PRESSED;
               end
            end
         end
         if (n > 0) begin
            prev.last = 1'b1;
            pending_reports.push_back(prev);
         end
         // apply queued presses
         for (int q = 0; q < press_count && q < kkh_pkg::SLOTS; q++) begin
            s = find_key(press_keys[q]);
            if (s < 0) begin
               s = find_free();
               if (s >= 0) begin
                  slot_used[s] = 1'b1;
                  slot_key[s]  = press_keys[q];
               end
            end
            if (s >= 0) begin
               slot_phase[s] = kkh_pkg::PH_PRESSED;
               slot_down[s]  = r.now_ms;
            end
         end
         press_count       = 0;
         events_since_poll = 0;
      endfunction

      function void check_response(kkh_pkg::rsp_type got);
         kkh_pkg::rsp_type want;
         if (pending_reports.size() == 0) begin
            $error("unexpected key report: id %0h key %0h state %0d last %0b",
                   got.report_id, got.report_key, got.key_state, got.last);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.report_id !== want.report_id) begin
            $error("report_id: expected %0h, actual %0h", want.report_id, got.report_id);
            errors++;
         end
         if (got.report_key !== want.report_key) begin
            $error("report_key: expected %0h, actual %0h", want.report_key, got.report_key);
            errors++;
         end
         if (got.key_state !== want.key_state) begin
            $error("key_state: expected %0d, actual %0d", want.key_state, got.key_state);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
         reports_checked++;
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   kkh_pkg::req_type req_data   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   kkh_pkg::rsp_type rsp_data;
   logic             csr_we     = 1'b0;
   logic             csr_index  = kkh_pkg::CSR_LONG_PRESS;
   logic [15:0]      csr_wdata  = 16'd0;

   key_report_board  board;
   kkh_pkg::req_type req_backlog[$];
   logic             req_busy          = 1'b0;
   logic             no_idle           = 1'b0;
   logic             hold_off_request  = 1'b0;
   logic             req_fire_n        = 1'b0;
   logic             rsp_fire_n        = 1'b0;
   kkh_pkg::rsp_type rsp_seen;
   logic [15:0]      cur_hold          = 16'd1000;
   logic [31:0]      now_base          = 32'd0;
   logic [7:0]       key_pool[POOL_SIZE];
   int               settings          = 1;

   keypad_key_hold_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Sample handshakes mid-cycle; they hold until the next rising edge
   always @(negedge clock) begin
      req_fire_n = !reset && req_valid && !req_stall;
      rsp_fire_n = !reset && rsp_valid && !rsp_stall;
      rsp_seen   = rsp_data;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_stall_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Request driver: holds payload until accepted, random gaps between requests
   initial begin : req_driver
      int gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (req_fire_n) begin
            board.predict_reports(req_data);
            req_busy = 1'b0;
            gap_left = pick_gap();
         end
         if (!req_busy) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               req_busy = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Report receiver: checks reports, drives random stall and the long hold-off
   initial begin : rsp_receiver
      int   run_left;
      int   hold_left;
      logic stalling;
      run_left  = 0;
      hold_left = 0;
      stalling  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_fire_n)
            board.check_response(rsp_seen);
         if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               stalling = !stalling;
               run_left = stalling ? pick_stall_len() : $urandom_range(1, 24);
            end
            run_left--;
            rsp_stall <= stalling;
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || req_fire_n || rsp_fire_n)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // One register write; the extra edge keeps back-to-back writes apart
   task automatic write_reg(input logic idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic push_event(input logic [7:0] k, input logic p);
      kkh_pkg::req_type r;
      r.func     = kkh_pkg::FUNC_EVENT;
      r.key_code = k;
      r.pressed  = p;
      r.now_ms   = $urandom;
      req_backlog.push_back(r);
   endtask

   task automatic push_poll(input logic [31:0] now);
      kkh_pkg::req_type r;
      r.func     = kkh_pkg::FUNC_POLL;
      r.key_code = 8'($urandom_range(0, 255));
      r.pressed  = 1'($urandom_range(0, 1));
      r.now_ms   = now;
      req_backlog.push_back(r);
   endtask

   task automatic wait_sent();
      while (req_backlog.size() != 0 || req_busy)
         @(posedge clock);
   endtask

   // Block is idle once all reports are in and any trailing event has been applied
   task automatic wait_drain();
      while (board.pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A run of raw events from the key pool, closed by a poll
   task automatic push_burst(inout int count);
      int          n_ev;
      int          pick;
      logic [31:0] step;
      n_ev = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 6);
      for (int i = 0; i < n_ev; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            push_event(key_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b1);
         else if (pick < 90)
            push_event(key_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b0);
         else
            push_event(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)
         step = $urandom_range(0, 2 * int'(cur_hold));
      else if (pick < 75)
         step = {16'd0, cur_hold};
      else if (pick < 85)
         step = {16'd0, cur_hold} - 32'd1;
      else if (pick < 95)
         step = $urandom;
      else
         step = 32'd0;
      now_base = now_base + step;
      push_poll(now_base);
      count += n_ev + 1;
   endtask

   task automatic run_phase(input logic [15:0] hold, input logic [7:0] id, input logic quiet);
      int         made;
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      write_reg(kkh_pkg::CSR_LONG_PRESS, hold);
      write_reg(kkh_pkg::CSR_KEYPAD_ID, {junk, id});
      cur_hold = hold;
      no_idle  = quiet;
      settings++;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = 8'($urandom_range(0, 255));
      made = 0;
      while (made < PHASE_ITEMS)
         push_burst(made);
      wait_sent();
      wait_drain();
   endtask

   initial begin : main
      int leftover;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, untracked release, hold threshold, repeat press
      push_poll(32'd0);
      push_event(8'h00, 1'b0);
      push_event(8'h00, 1'b1);
      push_event(8'hFF, 1'b1);
      push_poll(32'd100);
      push_poll(32'd1099);
      push_poll(32'd1100);
      push_event(8'h00, 1'b0);
      push_event(8'hFF, 1'b1);
      push_poll(32'd1200);
      // release twice, then poll at the top of the time range
      push_event(8'hFF, 1'b0);
      push_event(8'hFF, 1'b0);
      push_poll(32'hFFFF_FFFF);
      // too many events in one poll interval fills the table
      for (int i = 0; i < 9; i++)
         push_event(8'h10 + i[7:0], 1'b1);
      push_poll(32'hFFFF_FF00);
      // press with the table full, hold test across time wrap
      push_event(8'h55, 1'b1);
      push_poll(32'h0000_0400);
      wait_sent();
      wait_drain();

      // Long report hold-off with a full table so the block backs up
      now_base = 32'h0000_0400;
      hold_off_request = 1'b1;
      @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         now_base = now_base + 32'd10;
         push_poll(now_base);
      end
      wait_sent();
      wait_drain();

      // Empty the table before the random phases
      for (int i = 0; i < 8; i++)
         push_event(8'h10 + i[7:0], 1'b0);
      now_base = now_base + 32'd10;
      push_poll(now_base);
      wait_sent();
      wait_drain();

      run_phase(16'd1, 8'hFF, 1'b1);
      run_phase(16'd60000, 8'h00, 1'b0);
      run_phase(16'($urandom_range(50, 2000)), 8'($urandom_range(0, 255)), 1'b0);
      run_phase(16'($urandom_range(1, 60000)), 8'($urandom_range(0, 255)), 1'b0);

      leftover = board.pending_reports.size();
      if (leftover != 0) begin
         $error("%0d expected key reports never arrived", leftover);
         board.errors++;
      end
      $display("Ran %0d requests (%0d polls) under %0d register settings.",
               board.requests, board.polls, settings);
      $display("Checked %0d key reports, including a long report hold-off.",
               board.reports_checked);
      if (board.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
design/kkh_pkg.sv
design/kkh_front.sv
design/kkh_queue.sv
design/kkh_back.sv
design/keypad_key_hold_tracker.sv
design/kkh_checker.sv
tb/tb_top.sv
